/* rtl/imh_pkg.sv */
// Package for the indexed min-heap: sizes, state codes, status codes, opcodes and
// the command/status structs that pass between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package imh_pkg;

  localparam int CAPACITY     = 256;
  localparam int HANDLE_COUNT = 256;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_LAST_RD,
    S_LAST_WAIT,
    S_MOVE_LAST,
    S_START,
    S_RD,
    S_RD_R,
    S_CMP,
    S_PLACE,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIR_UNKNOWN,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef struct packed {
    logic latch_in;
    logic rd_handle;
    logic rd_last;
    logic move_last;
    logic start_append;
    logic start_sift;
    logic rd_level;
    logic rd_right;
    logic step;
    logic place;
    logic rd_root;
    logic set_present;
    logic clr_present;
    logic set_full;
    logic set_absent;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic present;
    logic full;
    logic has_last;
    logic sift_done;
  } dp_sts_t;

endpackage

/* rtl/imh_ctrl.sv */
// Controller state machine of the indexed min-heap.
// Depends on imh_pkg; drives the datapath through dp_cmd_t and reads dp_sts_t.
`timescale 1ns / 1ps
module imh_ctrl
  import imh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The output register is owned by the datapath; the block is ready only
  // when idle, which is after the previous result has been taken.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.rd_handle = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.kind == KIND_INSERT) begin
          if (sts.present) begin
            cmd.start_sift = 1'b1;
            state_nxt = S_RD;
          end else if (sts.full) begin
            cmd.set_full = 1'b1;
            state_nxt = S_ROOT_RD;
          end else begin
            cmd.start_append = 1'b1;
            cmd.set_present = 1'b1;
            state_nxt = S_RD;
          end
        end else begin
          if (!sts.present) begin
            cmd.set_absent = 1'b1;
            state_nxt = S_ROOT_RD;
          end else begin
            cmd.clr_present = 1'b1;
            state_nxt = S_LAST_RD;
          end
        end
      end
      S_LAST_RD: begin
        if (sts.has_last) begin
          cmd.rd_last = 1'b1;
          state_nxt = S_LAST_WAIT;
        end else begin
          state_nxt = S_ROOT_RD;
        end
      end
      S_LAST_WAIT: begin
        state_nxt = S_MOVE_LAST;
      end
      S_MOVE_LAST: begin
        cmd.move_last = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd_level = 1'b1;
        state_nxt = S_RD_R;
      end
      S_RD_R: begin
        cmd.rd_right = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.step = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        if (sts.sift_done) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_ROOT_RD;
      end
      S_ROOT_RD: begin
        cmd.rd_root = 1'b1;
        state_nxt = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes overlap");
  a_accept_go: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOKUP))
    else $error("accepted transaction did not start lookup");
  a_place_then_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place |=> cmd.rd_root)
    else $error("placement not followed by root read");
`endif

endmodule

/* rtl/imh_dp.sv */
// Datapath of the indexed min-heap: slot and handle memories, presence bits,
// fill count, sift walker and result register. Depends on imh_pkg.
`timescale 1ns / 1ps
module imh_dp
  import imh_pkg::*;
#(
  parameter int KEY_BITS     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  logic                  in_kind,
  input  logic [7:0]            in_handle,
  input  logic [KEY_BITS-1:0]   in_key,
  output logic [1:0]            out_status,
  output logic [KEY_BITS-1:0]   out_min_key,
  output logic [7:0]            out_min_handle,
  output logic [8:0]            out_entry_count,
  output logic [7:0]            out_final_slot,
  output logic                  out_empty_res
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;
  localparam int XW = SW + 2;

  logic [KEY_BITS-1:0] key_mem [CAPACITY];
  logic [HW-1:0]       hnd_mem [CAPACITY];
  logic [SW-1:0]       pos_mem [HANDLE_COUNT];
  logic [HANDLE_COUNT-1:0] present_r;

  logic [CW-1:0]       fill_r;
  logic                kind_r;
  logic [HW-1:0]       h_r;
  logic [KEY_BITS-1:0] k_r;
  logic [SW-1:0]       pos_q;
  logic [SW-1:0]       s_r;
  dir_t                dir_r;
  logic                done_r;
  logic [1:0]          status_r;
  logic                has_slot_r;
  logic [SW-1:0]       fslot_r;

  logic [KEY_BITS-1:0] kp_q, kl_q, kr_q;
  logic [HW-1:0]       hp_q, hl_q, hr_q;
  logic                lv_r, rv_r, pv_r;

  // Slot memories: one write port and two registered read ports. A sift level
  // reads the parent and the left child in one cycle and the right child in
  // the next one.
  logic                mw_en;
  logic [SW-1:0]       mw_addr;
  logic [KEY_BITS-1:0] mw_key;
  logic [HW-1:0]       mw_hnd;
  logic [SW-1:0]       ra_p, ra_l, ra_r;

  logic [XW-1:0] par_x, l_x, r_x;
  logic [CW-1:0] last_c;

  assign par_x  = ((XW'(s_r) + XW'(1)) >> 1) - XW'(1);
  assign l_x    = XW'(s_r) * XW'(2) + XW'(1);
  assign r_x    = XW'(s_r) * XW'(2) + XW'(2);
  assign last_c = fill_r - CW'(1);

  always_comb begin
    ra_p = par_x[SW-1:0];
    ra_l = l_x[SW-1:0];
    ra_r = r_x[SW-1:0];
    if (cmd.rd_last) begin
      // The count is already lowered here, so it indexes the old last slot.
      ra_p = fill_r[SW-1:0];
    end
    if (cmd.rd_root) begin
      ra_p = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_level || cmd.rd_last || cmd.rd_root) begin
      kp_q <= key_mem[ra_p];
      hp_q <= hnd_mem[ra_p];
    end
    if (cmd.rd_level) begin
      kl_q <= key_mem[ra_l];
      hl_q <= hnd_mem[ra_l];
    end
    if (cmd.rd_right) begin
      kr_q <= key_mem[ra_r];
      hr_q <= hnd_mem[ra_r];
    end
    if (mw_en) begin
      key_mem[mw_addr] <= mw_key;
      hnd_mem[mw_addr] <= mw_hnd;
    end
  end

  logic          pw_en;
  logic [HW-1:0] pw_addr;
  logic [SW-1:0] pw_data;

  always_ff @(posedge clk) begin
    if (cmd.rd_handle) begin
      pos_q <= pos_mem[h_r];
    end
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
  end

  // Sift step: compare the moving key with the neighbors read this level.
  logic          up_move, l_take, r_take;
  logic [SW-1:0] dn_slot;
  logic [KEY_BITS-1:0] dn_key;
  logic [HW-1:0] dn_hnd;

  always_comb begin
    up_move = pv_r && (kp_q > k_r) && (dir_r != DIR_DOWN);
    l_take  = lv_r && (kl_q < k_r);
    dn_key  = l_take ? kl_q : k_r;
    r_take  = rv_r && (kr_q < dn_key);
    dn_slot = r_take ? ra_r : ra_l;
    dn_hnd  = r_take ? hr_q : hl_q;
    if (r_take) begin
      dn_key = kr_q;
    end
  end

  always_comb begin
    mw_en = 1'b0;
    mw_addr = s_r;
    mw_key = k_r;
    mw_hnd = h_r;
    pw_en = 1'b0;
    pw_addr = h_r;
    pw_data = s_r;
    if (cmd.step && !done_r) begin
      if (up_move) begin
        mw_en = 1'b1;
        mw_key = kp_q;
        mw_hnd = hp_q;
        pw_en = 1'b1;
        pw_addr = hp_q;
      end else if (dir_r != DIR_UP && (l_take || r_take)) begin
        mw_en = 1'b1;
        mw_key = dn_key;
        mw_hnd = dn_hnd;
        pw_en = 1'b1;
        pw_addr = dn_hnd;
      end
    end
    if (cmd.place) begin
      mw_en = 1'b1;
      pw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_kind;
      h_r <= HW'(32'(in_handle) % HANDLE_COUNT);
      k_r <= in_key;
    end
    if (cmd.start_append) begin
      s_r <= fill_r[SW-1:0];
    end
    if (cmd.start_sift) begin
      s_r <= pos_q;
    end
    if (cmd.move_last) begin
      s_r <= pos_q;
      k_r <= kp_q;
      h_r <= hp_q;
    end
    if (cmd.rd_level) begin
      pv_r <= (s_r != '0);
      lv_r <= ({1'b0, l_x} < (XW+1)'(fill_r));
      rv_r <= ({1'b0, r_x} < (XW+1)'(fill_r));
    end
    if (cmd.start_append || cmd.start_sift || cmd.move_last) begin
      dir_r <= DIR_UNKNOWN;
      done_r <= 1'b0;
    end
    if (cmd.step && !done_r) begin
      if (up_move) begin
        s_r <= ra_p;
        dir_r <= DIR_UP;
      end else if (dir_r != DIR_UP && (l_take || r_take)) begin
        s_r <= dn_slot;
        dir_r <= DIR_DOWN;
      end else begin
        done_r <= 1'b1;
      end
    end
    if (cmd.latch_in) begin
      status_r <= ST_OK;
      has_slot_r <= 1'b0;
    end
    if (cmd.set_full) begin
      status_r <= ST_FULL;
    end
    if (cmd.set_absent) begin
      status_r <= ST_ABSENT;
    end
    if (cmd.place) begin
      has_slot_r <= (kind_r == KIND_INSERT);
      fslot_r <= s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      fill_r <= '0;
    end else begin
      if (cmd.set_present) begin
        present_r[h_r] <= 1'b1;
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.clr_present) begin
        present_r[h_r] <= 1'b0;
        fill_r <= last_c;
      end
    end
  end

  // After a delete, pos_q still holds the freed slot and fill_r the new count.
  assign sts.kind = kind_r;
  assign sts.present = present_r[h_r];
  assign sts.full = (fill_r >= CW'(CAPACITY));
  assign sts.has_last = ({1'b0, pos_q} < (SW+1)'(fill_r));
  assign sts.sift_done = done_r;

  logic nonempty;
  assign nonempty = (fill_r != '0);

  assign out_status = status_r;
  assign out_min_key = nonempty ? kp_q : '0;
  assign out_min_handle = nonempty ? 8'(hp_q) : 8'd0;
  assign out_entry_count = 9'(fill_r);
  assign out_final_slot = has_slot_r ? 8'(fslot_r) : 8'd0;
  assign out_empty_res = !nonempty;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count above capacity");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_present |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("append did not bump fill count");
  a_dir_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && dir_r == DIR_DOWN) |=> (dir_r == DIR_DOWN))
    else $error("sift changed direction");
`endif

endmodule

/* rtl/indexed_min_heap.sv */
// Top level of the indexed min-heap: joins the controller and the datapath.
// Depends on imh_pkg, imh_ctrl and imh_dp.
`timescale 1ns / 1ps
//
// Usage: one transaction on the in_ channel (kind, handle, key) inserts or
// updates the key of a handle (kind 0) or deletes a handle (kind 1). Each
// accepted transaction yields exactly one transaction on the out_ channel:
// status, root key and handle, entry count, final slot and an empty flag.
// Items are worked one at a time. A full-heap or absent-handle case and a delete
// of the last slot go from the handle lookup on to the root read; an insert or
// update sifts its entry level by level, and a delete that refills its slot
// first moves the last entry into it and then sifts it. The slot memory has two
// read ports, so a sift level reads parent and left child, then the right child,
// then compares and moves, then checks whether the sift is done.
// in_ready is high only while the block is idle, which is from the cycle after
// the result is accepted. The result is held on the out_ ports while out_ready
// is low, and no new transaction is taken until it is accepted. A synchronous
// active-low reset clears the presence bits and the entry count; the slot
// memories need no clearing since only live entries are ever used.
module indexed_min_heap
  import imh_pkg::*;
#(
  parameter int KEY_BITS     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [7:0]          in_handle,
  input  logic [KEY_BITS-1:0] in_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output logic [KEY_BITS-1:0] out_min_key,
  output logic [7:0]          out_min_handle,
  output logic [8:0]          out_entry_count,
  output logic [7:0]          out_final_slot,
  output logic                out_empty_res
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  imh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  imh_dp #(
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_handle       (in_handle),
    .in_key          (in_key),
    .out_status      (out_status),
    .out_min_key     (out_min_key),
    .out_min_handle  (out_min_handle),
    .out_entry_count (out_entry_count),
    .out_final_slot  (out_final_slot),
    .out_empty_res   (out_empty_res)
  );

endmodule

/* test/indexed_min_heap_tb.sv */
// Self-checking testbench for indexed_min_heap: inserts, key updates and deletes
// are predicted by a behavioral heap model and every result is compared field by field.
// Depends on imh_pkg and the indexed_min_heap RTL.
`timescale 1ns / 1ps
module indexed_min_heap_tb;
  import imh_pkg::*;

  localparam int NSLOT = 256;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [7:0]  in_handle;
  logic [63:0] in_key;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [63:0] out_min_key;
  logic [7:0]  out_min_handle;
  logic [8:0]  out_entry_count;
  logic [7:0]  out_final_slot;
  logic        out_empty_res;

  // One expected result of the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] min_key;
    logic [7:0]  min_handle;
    logic [8:0]  entry_count;
    logic [7:0]  final_slot;
    logic        empty_res;
  } heap_result_t;

  heap_result_t pending_results[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_off_cycles;

  // Shadow copy of the heap.
  logic [63:0] shadow_key[NSLOT];
  logic [7:0]  shadow_handle[NSLOT];
  logic [7:0]  shadow_pos[NSLOT];
  logic        shadow_live[NSLOT];
  int          shadow_fill;

  indexed_min_heap DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_handle(in_handle), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_min_key(out_min_key), .out_min_handle(out_min_handle),
    .out_entry_count(out_entry_count), .out_final_slot(out_final_slot),
    .out_empty_res(out_empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int parent_of(int i);
    return (i + 1) / 2 - 1;
  endfunction

  function automatic void put_entry(int s, logic [63:0] k, logic [7:0] h);
    shadow_key[s] = k;
    shadow_handle[s] = h;
    shadow_pos[h] = s[7:0];
  endfunction

  function automatic void bubble_up(int s);
    logic [63:0] k;
    logic [7:0]  h;
    k = shadow_key[s];
    h = shadow_handle[s];
    while (s > 0 && shadow_key[parent_of(s)] > k) begin
      put_entry(s, shadow_key[parent_of(s)], shadow_handle[parent_of(s)]);
      s = parent_of(s);
    end
    put_entry(s, k, h);
  endfunction

  function automatic void bubble_down(int s);
    logic [63:0] k;
    logic [63:0] bk;
    logic [7:0]  h;
    int          best;
    k = shadow_key[s];
    h = shadow_handle[s];
    forever begin
      best = s;
      bk = k;
      if (s * 2 + 1 < shadow_fill && shadow_key[s * 2 + 1] < bk) begin
        best = s * 2 + 1;
        bk = shadow_key[best];
      end
      if (s * 2 + 2 < shadow_fill && shadow_key[s * 2 + 2] < bk) begin
        best = s * 2 + 2;
        bk = shadow_key[best];
      end
      if (best == s) break;
      put_entry(s, shadow_key[best], shadow_handle[best]);
      s = best;
    end
    put_entry(s, k, h);
  endfunction

  // The root always sifts down; elsewhere the entry goes up when its parent is larger.
  function automatic void restore_order(int s);
    if (s > 0 && shadow_key[parent_of(s)] > shadow_key[s]) bubble_up(s);
    else bubble_down(s);
  endfunction

  function automatic heap_result_t apply_heap_op(logic kind, logic [7:0] h, logic [63:0] k);
    heap_result_t r;
    int           s;
    r = '0;
    if (kind == KIND_INSERT) begin
      if (shadow_live[h]) begin
        s = shadow_pos[h];
        shadow_key[s] = k;
        restore_order(s);
        r.final_slot = shadow_pos[h];
      end else if (shadow_fill >= NSLOT) begin
        r.status = ST_FULL;
      end else begin
        s = shadow_fill;
        put_entry(s, k, h);
        shadow_live[h] = 1'b1;
        shadow_fill = s + 1;
        restore_order(s);
        r.final_slot = shadow_pos[h];
      end
    end else begin
      if (!shadow_live[h]) begin
        r.status = ST_ABSENT;
      end else begin
        s = shadow_pos[h];
        shadow_live[h] = 1'b0;
        shadow_fill = shadow_fill - 1;
        if (s < shadow_fill) begin
          put_entry(s, shadow_key[shadow_fill], shadow_handle[shadow_fill]);
          restore_order(s);
        end
      end
    end
    r.entry_count = shadow_fill[8:0];
    r.empty_res = (shadow_fill == 0);
    if (shadow_fill != 0) begin
      r.min_key = shadow_key[0];
      r.min_handle = shadow_handle[0];
    end
    return r;
  endfunction

  // Drives one transaction and records its expected result on acceptance.
  // Valid stays up until the next call idles or the drain lowers it.
  task automatic send_op(logic kind, logic [7:0] h, logic [63:0] k);
    heap_result_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_handle <= h;
    in_key <= k;
    do @(posedge clk); while (!in_ready);
    expected = apply_heap_op(kind, h, k);
    pending_results.insert(pending_results.size(), expected);
    @(negedge clk);
  endtask

  // Random keys lean toward a few small and a few near-maximal values so equal keys show up often.
  function automatic logic [63:0] pick_key();
    case ($urandom_range(3))
      0: return 64'($urandom_range(7));
      1: return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_op(KIND_DELETE, 8'd0, '0);                     // delete on an empty heap
    send_op(KIND_INSERT, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_INSERT, 8'd0, 64'd0);
    send_op(KIND_INSERT, 8'd7, 64'd0);                  // equal to the root
    send_op(KIND_INSERT, 8'd8, 64'd5);
    send_op(KIND_INSERT, 8'd9, 64'd5);                  // equal to its parent
    send_op(KIND_INSERT, 8'd0, 64'd100);                // update at the root sifts down
    send_op(KIND_INSERT, 8'd255, 64'd0);                // update moves up
    send_op(KIND_DELETE, 8'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_DELETE, 8'd77, '0);                    // absent handle
    send_op(KIND_DELETE, 8'd9, '0);
    send_op(KIND_DELETE, 8'd0, '0);
    send_op(KIND_DELETE, 8'd255, '0);
    send_op(KIND_DELETE, 8'd8, '0);                     // back to empty
  endtask

  // Fills all slots, updates and swaps entries on a full heap, then drains partly.
  task automatic test_full_heap();
    for (int h = 0; h < NSLOT; h++) send_op(KIND_INSERT, h[7:0], pick_key());
    send_op(KIND_INSERT, 8'd12, 64'd1);                 // present: update still works
    for (int h = 0; h < 4; h++) begin
      send_op(KIND_DELETE, 8'($urandom), '0);
      send_op(KIND_INSERT, 8'($urandom), pick_key());
    end
    for (int h = 0; h < NSLOT; h += 4) send_op(KIND_DELETE, h[7:0], '0);
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 55) send_op(KIND_INSERT, 8'($urandom), pick_key());
      else send_op(KIND_DELETE, 8'($urandom), {$urandom, $urandom});
    end
  endtask

  // Holds the result port off for a long stretch while transactions keep coming.
  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int n = 0; n < 20; n++) send_op(n[0], 8'($urandom_range(40)), pick_key());
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  // Receiver: ready timing and the long hold-off.
  initial begin
    out_ready = 1'b0;
    hold_off_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result checker.
  initial begin
    heap_result_t want;
    heap_result_t got;
    mismatch_count = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_status, out_min_key, out_min_handle, out_entry_count,
                out_final_slot, out_empty_res};
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result transaction: %p", got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Result mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_INSERT;
    in_handle = '0;
    in_key = '0;
    send_idle_pct = 7;
    recv_idle_pct = 61;
    shadow_fill = 0;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_live[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_handle[i] = '0;
      shadow_pos[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(30);
    send_idle_pct = 61;
    recv_idle_pct = 7;
    test_full_heap();
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(50);
    drain();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
